// ----- design/ccq_pkg.sv -----
// ----------------------------------------------------------------------------
// ccq_pkg
// Types and constants shared by the calendar clock and its event queue.
// ----------------------------------------------------------------------------
package ccq_pkg;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_REL  = 2'd1;
  localparam logic [1:0] ACT_ABS  = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic [2:0] K_IDLE  = 3'd0;
  localparam logic [2:0] K_DAY   = 3'd1;
  localparam logic [2:0] K_DUE   = 3'd2;
  localparam logic [2:0] K_QUEUE = 3'd3;
  localparam logic [2:0] K_PAST  = 3'd4;
  localparam logic [2:0] K_FULL  = 3'd5;
  localparam logic [2:0] K_IMM   = 3'd6;

  localparam logic [0:0] REG_TPD  = 1'b0;
  localparam logic [0:0] REG_YEAR = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  month_value;
    logic [7:0]  day_value;
    logic [15:0] year_value;
    logic [7:0]  event_code;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  code_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        last;
  } out_t;

  // queue entry: date key (year, month, day) plus code
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  code;
  } ev_t;

  // control from sequencer to each cell
  typedef struct packed {
    logic       ins;   // insert key/new entry
    logic       pop;   // shift toward head
  } cell_ctl_t;

  function automatic logic leap(input logic [17:0] y);
    logic [17:0] prod;
    logic        div25;
    // y times the inverse of 25 mod 2^18 is small exactly when 25 divides y
    prod  = 18'(y * 18'h35C29);
    div25 = (prod <= 18'd10485);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_of(input logic [3:0] m, input logic [17:0] y);
    logic [4:0] d;
    unique case (m)
      4'd2:                      d = leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- design/ccq_cell.sv -----
// ----------------------------------------------------------------------------
// ccq_cell
// One slot of the sorted queue. Inserts in parallel compare; pops shift.
// ----------------------------------------------------------------------------
module ccq_cell
  import ccq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,       // this slot holds a valid entry
  input  logic      prev_gt,   // previous slot's entry is after the new key
  input  logic      prev_occ,
  input  ev_t       prev_ev,
  input  ev_t       next_ev,
  input  ev_t       new_ev,
  output logic      gt,        // this entry is strictly after the new key
  output ev_t       ev
);

  logic [24:0] key_self, key_new;
  assign key_self = {ev.year, ev.month, ev.day};
  assign key_new  = {new_ev.year, new_ev.month, new_ev.day};
  assign gt = occ && (key_self > key_new);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      ev <= next_ev;
    end else if (ctl.ins) begin
      // entries after the key move back one; first such slot takes new
      if (prev_gt && prev_occ) ev <= prev_ev;
      else if (gt || !occ) ev <= new_ev;
    end
  end

endmodule

// ----- design/calendar_clock_with_date_event_queue.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_with_date_event_queue
// Tick counter, Gregorian calendar and a date-sorted event queue.
// ----------------------------------------------------------------------------
// Input transactions (valid/ready) carry a tick or an event request. Each
// produces one or more output transactions; last marks the final one.
// An absolute request, an ignored action or a tick that leaves the date
// alone goes from idle straight to the check state, which emits its result
// once the output is free. A relative request first normalizes its day,
// carrying one month per step, before the check. An advancing tick emits
// the new date, then one due event per cycle from the head cell while the output is free.
// The queue is a row of QUEUE_DEPTH cells; an insert is made by
// a compare in every cell and a shift of later entries.
// One input is worked at a time; ready is low while results remain and
// returns in the cycle the final result is taken.
// The output register holds its value while out_ready is low and the
// sequencer waits. Reset sets the date to 17 Feb 2155, empties the queue
// and clears registers. Config writes go to the write port (index 0
// ticks_per_day, 1 the calendar year, loaded into the date at once).
// ----------------------------------------------------------------------------
module calendar_clock_with_date_event_queue
  import ccq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [23:0] ticks_per_day, ticks_left;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [15:0] cur_year;
  logic [CW-1:0] count;
  in_t         req;
  logic [8:0]  wd;
  logic [3:0]  wm;
  logic [17:0] wy;

  ev_t  cev [QUEUE_DEPTH];
  logic cgt [QUEUE_DEPTH];
  logic cocc [QUEUE_DEPTH];
  cell_ctl_t ctl;
  ev_t  new_ev;

  assign new_ev = '{year: wy[15:0], month: wm, day: wd[4:0], code: req.event_code};

  genvar g;
  for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign cocc[g] = CW'(g) < count;
    ccq_cell u_cell (
      .clk(clk), .ctl(ctl), .occ(cocc[g]),
      .prev_gt(g == 0 ? 1'b0 : cgt[(g == 0) ? 0 : g-1]),
      .prev_occ(g == 0 ? 1'b0 : cocc[(g == 0) ? 0 : g-1]),
      .prev_ev(cev[(g == 0) ? 0 : g-1]),
      .next_ev(cev[(g == QUEUE_DEPTH-1) ? g : g+1]),
      .new_ev(new_ev), .gt(cgt[g]), .ev(cev[g]));
  end

  logic [24:0] now_key, w_key, head_key, next_key;
  assign now_key  = {cur_year, cur_month, cur_day};
  assign w_key    = {wy[15:0], wm, wd[4:0]};
  assign head_key = {cev[0].year, cev[0].month, cev[0].day};
  assign next_key = {cev[1 % QUEUE_DEPTH].year, cev[1 % QUEUE_DEPTH].month,
                     cev[1 % QUEUE_DEPTH].day};

  logic [4:0] wlen;
  assign wlen = days_of(wm, wy);
  logic [4:0] clen;
  assign clen = days_of(cur_month, {2'b00, cur_year});

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;

  logic is_add, rel_zero, rel_ovf, abs_bad, head_due, next_due;
  assign is_add   = (req.action == ACT_REL) || (req.action == ACT_ABS);
  assign rel_zero = (req.action == ACT_REL) && (req.month_value == '0) &&
                    (req.day_value == '0) && (req.year_value == '0);
  assign rel_ovf  = (req.action == ACT_REL) && (wy[17:16] != 2'b00);
  assign abs_bad  = (req.action == ACT_ABS) && (wm < 4'd1 || wm > 4'd12 ||
                    wd == 9'd0 || wd > 9'(wlen));
  assign head_due = (count != '0) && (head_key <= now_key);
  assign next_due = (count > CW'(1)) && (next_key <= now_key);

  always_comb begin
    ctl = '0;
    if (state == S_CHK && is_add && !rel_zero && out_free && !rel_ovf &&
        !abs_bad && !(w_key < now_key) && count != CW'(QUEUE_DEPTH))
      ctl.ins = 1'b1;
    if (state == S_POP && out_free && head_due)
      ctl.pop = 1'b1;
  end

  always_ff @(posedge clk) begin
    logic [4:0]  mtmp;
    logic [17:0] ytmp;
    out_t        o;
    logic        emit;
    logic [2:0]  nstate;
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      ticks_per_day <= '0; ticks_left <= '0;
      cur_day <= 5'd17; cur_month <= 4'd2; cur_year <= 16'd2155;
      count <= '0;
    end else begin
      emit   = 1'b0;
      o      = out_data;
      nstate = state;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TPD:  ticks_per_day <= cfg_wdata;
          REG_YEAR: cur_year <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (ctl.ins) count <= count + 1'b1;
      if (ctl.pop) count <= count - 1'b1;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          req <= in_data;
          mtmp = 5'(in_data.month_value) + 5'(cur_month) - 5'd1;
          ytmp = 18'(in_data.year_value) + 18'(cur_year);
          if (in_data.action == ACT_REL) begin
            if (mtmp >= 5'd24) begin
              wm <= 4'(mtmp - 5'd24 + 5'd1); wy <= ytmp + 18'd2;
            end else if (mtmp >= 5'd12) begin
              wm <= 4'(mtmp - 5'd12 + 5'd1); wy <= ytmp + 18'd1;
            end else begin
              wm <= 4'(mtmp + 5'd1); wy <= ytmp;
            end
            wd <= 9'(in_data.day_value) + 9'(cur_day);
            nstate = S_NORM;
          end else begin
            wm <= in_data.month_value; wd <= 9'(in_data.day_value);
            wy <= 18'(in_data.year_value);
            nstate = S_CHK;
          end
        end
        S_NORM: begin
          if (wd > 9'(wlen)) begin
            wd <= wd - 9'(wlen);
            if (wm >= 4'd12) begin wm <= 4'd1; wy <= wy + 18'd1; end
            else wm <= wm + 4'd1;
          end else nstate = S_CHK;
        end
        S_CHK: if (out_free) begin
          emit = 1'b1;
          o = '{kind: K_IDLE, code_out: 8'd0, day_out: cur_day,
                month_out: cur_month, year_out: cur_year, last: 1'b1};
          nstate = S_IDLE;
          if (req.action == ACT_TICK) begin
            if (ticks_left > 24'd1) ticks_left <= ticks_left - 24'd1;
            else begin
              ticks_left <= ticks_per_day;
              if (ticks_per_day != '0) begin
                if (cur_day >= clen) begin
                  cur_day <= 5'd1;
                  if (cur_month >= 4'd12) begin
                    cur_month <= 4'd1; cur_year <= cur_year + 16'd1;
                  end else cur_month <= cur_month + 4'd1;
                end else cur_day <= cur_day + 5'd1;
                emit = 1'b0;
                nstate = S_OUT;
              end
            end
          end else if (rel_zero) begin
            o.kind = K_IMM; o.code_out = req.event_code;
          end else if (is_add) begin
            o.day_out = wd[4:0]; o.month_out = wm;
            o.year_out = wy[15:0];
            if (rel_ovf) begin
              o.kind = K_PAST; o.year_out = 16'hFFFF;
            end else if (!ctl.ins) begin
              o.kind = (abs_bad || w_key < now_key) ? K_PAST : K_FULL;
            end else begin
              o.kind = K_QUEUE; o.code_out = req.event_code;
            end
          end
        end
        S_OUT: begin
          // date already advanced; emit it, then scan due events
          emit = 1'b1;
          o = '{kind: K_DAY, code_out: 8'd0, day_out: cur_day,
                month_out: cur_month, year_out: cur_year, last: !head_due};
          nstate = head_due ? S_POP : S_IDLE;
        end
        S_POP: if (out_free) begin
          emit = 1'b1;
          o = '{kind: K_DUE, code_out: cev[0].code, day_out: cev[0].day,
                month_out: cev[0].month, year_out: cev[0].year,
                last: !next_due};
          if (!next_due) nstate = S_IDLE;
        end
        default: nstate = S_IDLE;
      endcase
      state    <= nstate;
      out_data <= o;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- tb/calendar_clock_with_date_event_queue_chk.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_with_date_event_queue_chk
// Watches both channels and the register port, predicts each result
// transaction from a local calendar and event-queue model, and compares.
// ----------------------------------------------------------------------------
module calendar_clock_with_date_event_queue_chk
  import ccq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int unsigned d, m, y, code;
  } cal_ev_t;

  int unsigned tpd, left, day, mon, yr;
  cal_ev_t     agenda[$];
  out_t        due_results[$];

  assign pending = due_results.size();

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) return 31;
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic longint unsigned key_of(int unsigned d, int unsigned m,
                                             int unsigned y);
    return (longint'(y) << 9) | ((m & 15) << 5) | (d & 31);
  endfunction

  function automatic void add_result(logic [2:0] k, int unsigned code, int unsigned d,
                                     int unsigned m, int unsigned y, bit lst);
    out_t r;
    r.kind = k;
    r.code_out = code[7:0];
    r.day_out = d[4:0];
    r.month_out = m[3:0];
    r.year_out = y[15:0];
    r.last = lst;
    due_results.push_back(r);
  endfunction

  function automatic void advance(in_t t);
    int unsigned d, m, y, pos;
    longint unsigned k;
    cal_ev_t e;
    if (t.action == ACT_TICK) begin
      if (left > 1) begin
        left--;
        add_result(K_IDLE, 0, day, mon, yr, 1);
        return;
      end
      left = tpd;
      if (tpd == 0) begin
        add_result(K_IDLE, 0, day, mon, yr, 1);
        return;
      end
      day++;
      if (day > month_days(mon, yr)) begin
        day = 1;
        mon++;
        if (mon > 12) begin
          mon = 1;
          yr = (yr + 1) & 32'hFFFF;
        end
      end
      k = key_of(day, mon, yr);
      add_result(K_DAY, 0, day, mon, yr, 0);
      while (agenda.size() > 0 && key_of(agenda[0].d, agenda[0].m, agenda[0].y) <= k) begin
        add_result(K_DUE, agenda[0].code, agenda[0].d, agenda[0].m, agenda[0].y, 0);
        void'(agenda.pop_front());
      end
      due_results[$].last = 1'b1;
      return;
    end
    if (t.action != ACT_REL && t.action != ACT_ABS) begin
      add_result(K_IDLE, 0, day, mon, yr, 1);
      return;
    end
    if (t.action == ACT_REL) begin
      if (t.month_value == 0 && t.day_value == 0 && t.year_value == 0) begin
        add_result(K_IMM, 32'(t.event_code), day, mon, yr, 1);
        return;
      end
      m = 32'(t.month_value) + mon - 1;
      y = 32'(t.year_value) + yr + m / 12;
      m = m % 12 + 1;
      d = 32'(t.day_value) + day;
      while (d > month_days(m, y)) begin
        d -= month_days(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      if (y > 65535) begin
        add_result(K_PAST, 0, d, m, 65535, 1);
        return;
      end
    end else begin
      d = 32'(t.day_value);
      m = 32'(t.month_value);
      y = 32'(t.year_value);
      if (m < 1 || m > 12 || d < 1 || d > month_days(m, y)) begin
        add_result(K_PAST, 0, d, m, y, 1);
        return;
      end
    end
    k = key_of(d, m, y);
    if (k < key_of(day, mon, yr)) begin
      add_result(K_PAST, 0, d, m, y, 1);
      return;
    end
    if (agenda.size() >= QUEUE_DEPTH) begin
      add_result(K_FULL, 0, d, m, y, 1);
      return;
    end
    pos = 0;
    while (pos < agenda.size() && key_of(agenda[pos].d, agenda[pos].m, agenda[pos].y) <= k)
      pos++;
    e.d = d;
    e.m = m;
    e.y = y;
    e.code = 32'(t.event_code);
    agenda.insert(pos, e);
    add_result(K_QUEUE, 32'(t.event_code), d, m, y, 1);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      tpd = 0;
      left = 0;
      day = 17;
      mon = 2;
      yr = 2155;
      agenda.delete();
      due_results.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TPD) tpd = 32'(cfg_wdata);
        else yr = 32'(cfg_wdata[15:0]);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %p", out_data);
        end else begin
          want = due_results.pop_front();
          if (want != out_data) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
      if (in_valid && in_ready) advance(in_data);
    end
  end
endmodule

// ----- tb/calendar_clock_with_date_event_queue_tb.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_with_date_event_queue_tb
// Drives ticks and event requests with random gaps and back-pressure,
// across several register settings; the checker scores every result.
// ----------------------------------------------------------------------------
module calendar_clock_with_date_event_queue_tb
  import ccq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_t         in_data;
  out_t        out_data;
  logic        cfg_we, cfg_index;
  logic [23:0] cfg_wdata;
  int          errors, pending;
  int          cycles = 0;
  bit          calm, hold_off;

  calendar_clock_with_date_event_queue dut (.*);
  calendar_clock_with_date_event_queue_chk chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("calendar_clock_with_date_event_queue_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    bit held;
    held = 0;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  task automatic send(in_t t);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic in_t pick(logic [1:0] a, int m, int d, int y, int c);
    in_t t;
    t.action = a;
    t.month_value = 4'(m);
    t.day_value = 8'(d);
    t.year_value = 16'(y);
    t.event_code = 8'(c);
    return t;
  endfunction

  function automatic in_t rand_item();
    int r;
    r = $urandom_range(99);
    if (r < 40) return pick(ACT_TICK, $urandom, $urandom, $urandom, $urandom);
    if (r < 65) return pick(ACT_REL, $urandom_range(3), $urandom_range(40),
                            $urandom_range(1) ? 0 : $urandom_range(1), $urandom);
    if (r < 85) return pick(ACT_ABS, $urandom_range(1, 12), $urandom_range(1, 31),
                            2155 + $urandom_range(1), $urandom);
    if (r < 95) return pick($urandom_range(1) ? ACT_REL : ACT_ABS,
                            $urandom, $urandom, $urandom, $urandom);
    return pick(ACT_NOP, $urandom, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = REG_TPD;
    cfg_wdata = 0;
    calm = 0;
    hold_off = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // clock stopped: idle ticks and the request special cases
    send(pick(ACT_TICK, 0, 0, 0, 0));
    send(pick(ACT_REL, 0, 0, 0, 8'hFF));
    send(pick(ACT_REL, 15, 255, 16'hFFFF, 1));
    send(pick(ACT_ABS, 0, 1, 2155, 2));
    send(pick(ACT_ABS, 13, 1, 2155, 3));
    send(pick(ACT_ABS, 2, 30, 2156, 4));
    send(pick(ACT_ABS, 2, 29, 2156, 5));
    send(pick(ACT_ABS, 2, 16, 2155, 6));
    send(pick(ACT_ABS, 12, 0, 2155, 7));
    send(pick(ACT_NOP, 15, 255, 16'hFFFF, 8'hFF));
    drain();
    write_reg(REG_TPD, 24'd1);
    write_reg(REG_YEAR, 24'hFFFF);
    // last calendar year: fill the queue past capacity, then tick out due events
    for (int i = 0; i < 19; i++) send(pick(ACT_REL, 0, 13 + i, 0, i));
    send(pick(ACT_ABS, 12, 31, 16'hFFFF, 9));
    for (int i = 0; i < 20; i++) send(pick(ACT_TICK, 0, 0, 0, 0));
    drain();
    write_reg(REG_YEAR, 24'd2155);
    write_reg(REG_TPD, 24'hFFFFFF);
    send(pick(ACT_TICK, 0, 0, 0, 0));
    send(pick(ACT_TICK, 0, 0, 0, 0));
    drain();
    write_reg(REG_TPD, 24'd2);
    hold_off = 1;
    for (int i = 0; i < 50; i++) begin
      calm = (i >= 20 && i < 40);
      send(rand_item());
    end
    drain();
    write_reg(REG_TPD, 24'd1);
    write_reg(REG_YEAR, 24'd0);
    for (int i = 0; i < 28; i++) send(rand_item());
    drain();
    if (errors == 0) begin
      $display("calendar_clock_with_date_event_queue_tb: clean");
    end else begin
      $display("calendar_clock_with_date_event_queue_tb: errors");
    end
    $finish;
  end
endmodule
